// ===== rtl/cdpm_pkg.sv =====
// Shared types, constants and helper functions for the character display
// pixel map controller. No dependencies; every other file imports this one.
`timescale 1ns / 1ps
`default_nettype none

package cdpm_pkg;

   // Sizing of the display and the daisy chain.
   localparam int MAX_CHARS   = 8;
   localparam int MAX_DEVICES = 4;
   localparam int GLYPH_COLS  = 5;
   localparam int MAP_DEPTH   = GLYPH_COLS * MAX_CHARS;
   localparam int MAP_AW      = $clog2(MAP_DEPTH);
   localparam int MAP_CW      = $clog2(MAP_DEPTH + 1);
   localparam int GLYPH_DEPTH = 475;
   localparam int GLYPH_AW    = $clog2(GLYPH_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Field widths that the interface fixes.
   localparam int DEV_W  = 3;
   localparam int LEN_W  = 4;
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 3;

   // Character range covered by the glyph store.
   localparam logic [7:0] FIRST_CODE = 8'h20;
   localparam logic [7:0] LAST_CODE  = 8'h7e;

   // Control word layout: sleep bit (high means awake), current code, brightness.
   localparam logic [7:0] CONTROL_RESET = 8'h4f;
   localparam int         SLEEP_BIT     = 6;
   localparam logic [7:0] CURRENT_MAX   = 8'd3;
   localparam logic [7:0] BRIGHT_MAX    = 8'd15;

   typedef enum logic [2:0] {
      OP_WRITE   = 3'd0,
      OP_SETPOS  = 3'd1,
      OP_CLEAR   = 3'd2,
      OP_SLEEP   = 3'd3,
      OP_CURRENT = 3'd4,
      OP_BRIGHT  = 3'd5,
      OP_UPDATE  = 3'd6,
      OP_LOAD    = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACK   = 2'd0,
      KIND_CTRL  = 2'd1,
      KIND_PIXEL = 2'd2,
      KIND_EMPTY = 2'd3
   } kind_type;

   typedef enum logic [0:0] {
      CSR_DEVICE_COUNT = 1'b0,
      CSR_CHAR_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GLYPH,
      ST_CTRL,
      ST_PIX_RD,
      ST_PIX_OUT,
      ST_ACK
   } state_type;

   // A classified request as it travels from the front part to the back part.
   typedef struct packed {
      op_type                op;
      logic [GLYPH_AW-1:0]   glyph_base;
      logic [LEN_W-1:0]      position;
      logic                  sleep;
      logic [1:0]            current_code;
      logic [3:0]            brightness;
      logic [GLYPH_AW-1:0]   glyph_addr;
      logic [7:0]            glyph_byte;
      logic                  load_ok;
   } cmd_type;

   // Head of the command queue as seen by the back part.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   // Peak current index to its two-bit field code.
   function automatic logic [1:0] current_code(input logic [1:0] idx);
      logic [1:0] code;
      unique case (idx)
         2'd0:    code = 2'b10;
         2'd1:    code = 2'b01;
         2'd2:    code = 2'b00;
         default: code = 2'b11;
      endcase
      return code;
   endfunction

   // Character length in use: zero counts as one, capped at the map size.
   function automatic logic [LEN_W-1:0] eff_length(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] n;
      n = len;
      if (n == '0) n = LEN_W'(1);
      if (n > LEN_W'(MAX_CHARS)) n = LEN_W'(MAX_CHARS);
      return n;
   endfunction

   // Device count in use, capped at the chain length supported.
   function automatic logic [DEV_W-1:0] eff_devices(input logic [DEV_W-1:0] cnt);
      logic [DEV_W-1:0] n;
      n = cnt;
      if (n > DEV_W'(MAX_DEVICES)) n = DEV_W'(MAX_DEVICES);
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cdpm_front.sv =====
// Front part: takes request items and classifies them into queue commands.
// Depends on cdpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdpm_front
   import cdpm_pkg::*;
(
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [2:0]          req_type,
   input  wire logic [7:0]          req_char_code,
   input  wire logic [7:0]          req_new_position,
   input  wire logic                req_sleep_flag,
   input  wire logic [7:0]          req_current_level,
   input  wire logic [7:0]          req_brightness_level,
   input  wire logic [8:0]          req_glyph_addr,
   input  wire logic [7:0]          req_glyph_byte,
   input  wire logic [LEN_W-1:0]    eff_len,
   input  wire logic                queue_full,
   output logic                     push,
   output cmd_type                  push_cmd
);

   logic [7:0] code_fixed;
   logic [6:0] code_idx;
   logic [1:0] current_idx;

   // An item is taken whenever the queue has a free slot.
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Out-of-range characters draw the last glyph; base address is index times five.
   always_comb begin
      if (req_char_code < FIRST_CODE || req_char_code > LAST_CODE) begin
         code_fixed = LAST_CODE;
      end else begin
         code_fixed = req_char_code;
      end
      code_idx = 7'(code_fixed - FIRST_CODE);
   end

   // Saturate the current index before mapping it to its field code.
   assign current_idx = (req_current_level > CURRENT_MAX) ? 2'(CURRENT_MAX)
                                                          : req_current_level[1:0];

   // Pack the classified command.
   always_comb begin
      push_cmd.op           = op_type'(req_type);
      push_cmd.glyph_base   = GLYPH_AW'({2'b00, code_idx}) + GLYPH_AW'({code_idx, 2'b00});
      if (req_new_position >= 8'(eff_len)) begin
         push_cmd.position = eff_len - LEN_W'(1);
      end else begin
         push_cmd.position = req_new_position[LEN_W-1:0];
      end
      push_cmd.sleep        = req_sleep_flag;
      push_cmd.current_code = current_code(current_idx);
      push_cmd.brightness   = (req_brightness_level > BRIGHT_MAX) ? 4'(BRIGHT_MAX)
                                                                  : req_brightness_level[3:0];
      push_cmd.glyph_addr   = GLYPH_AW'(req_glyph_addr);
      push_cmd.glyph_byte   = req_glyph_byte;
      push_cmd.load_ok      = (req_glyph_addr < 9'(GLYPH_DEPTH));
   end

endmodule

`default_nettype wire

// ===== rtl/cdpm_cmd_queue.sv =====
// Short command queue between the front and back parts.
// Depends on cdpm_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module cdpm_cmd_queue
   import cdpm_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  cmd_type        push_cmd,
   output logic           full,
   input  wire logic      pop,
   output queue_head_type head
);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cdpm_back.sv =====
// Back part: carries out queued commands, holds the pixel map, glyph store and
// control word, and drives the registered result channel. Depends on cdpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdpm_back
   import cdpm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  queue_head_type        head,
   output logic                  pop,
   input  wire logic [LEN_W-1:0] eff_len,
   input  wire logic [DEV_W-1:0] eff_devs,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_reg_select,
   output logic                  rsp_frame_end,
   output logic [3:0]            rsp_cursor,
   output logic                  rsp_last
);

   state_type             state_ff, state_in;
   logic [LEN_W-1:0]      cursor_ff;
   logic [7:0]            control_ff;
   logic                  cdirty_ff;
   logic                  pdirty_ff;
   logic                  upd_pix_ff;
   logic [MAP_CW-1:0]     cnt_ff;
   logic [GLYPH_AW-1:0]   glyph_base_ff;
   kind_type              ack_kind_ff;
   logic [MAP_DEPTH-1:0]  map_vld_ff;

   logic [7:0]            glyph_mem [GLYPH_DEPTH];
   logic [7:0]            map_mem [MAP_DEPTH];
   logic [7:0]            glyph_rd_ff;
   logic [7:0]            map_rd_ff;
   logic                  map_rd_vld_ff;

   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff;
   logic [7:0]            rsp_byte_ff;
   logic                  rsp_rs_ff;
   logic                  rsp_fe_ff;
   logic [3:0]            rsp_cursor_ff;
   logic                  rsp_last_ff;

   logic                  write_ok;
   logic                  ctrl_send;
   logic [MAP_CW-1:0]     nbytes;
   logic                  dev_last;
   logic                  pix_last;
   logic                  out_free;
   logic                  emit;
   logic                  fire;
   kind_type              e_kind;
   logic [7:0]            e_byte;
   logic                  e_rs;
   logic                  e_fe;
   logic                  e_last;
   logic                  glyph_we;
   logic                  glyph_re;
   logic                  map_we;
   logic                  map_re;
   logic [GLYPH_AW-1:0]   glyph_raddr;
   logic [MAP_AW-1:0]     map_base;
   logic [MAP_AW-1:0]     map_waddr;
   logic [MAP_AW-1:0]     map_raddr;

   // Shared conditions.
   assign write_ok  = (cursor_ff < eff_len);
   assign ctrl_send = cdirty_ff && (eff_devs != '0);
   assign nbytes    = MAP_CW'({eff_len, 2'b00}) + MAP_CW'(eff_len);
   assign dev_last  = ((cnt_ff + 1'b1) == MAP_CW'(eff_devs));
   assign pix_last  = ((cnt_ff + 1'b1) == nbytes);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = emit && out_free;

   // Address arithmetic for the two memories.
   assign map_base    = (MAP_AW'(cursor_ff) << 2) + MAP_AW'(cursor_ff);
   assign map_waddr   = map_base + cnt_ff[MAP_AW-1:0] - 1'b1;
   assign map_raddr   = cnt_ff[MAP_AW-1:0];
   assign glyph_raddr = glyph_base_ff + GLYPH_AW'(cnt_ff);
   assign glyph_we    = pop && (head.cmd.op == OP_LOAD) && head.cmd.load_ok;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               unique case (head.cmd.op)
                  OP_WRITE:  state_in = write_ok ? ST_GLYPH : ST_ACK;
                  OP_UPDATE: begin
                     if (ctrl_send) begin
                        state_in = ST_CTRL;
                     end else if (pdirty_ff) begin
                        state_in = ST_PIX_RD;
                     end else begin
                        state_in = ST_ACK;
                     end
                  end
                  default:   state_in = ST_ACK;
               endcase
            end
         end
         ST_GLYPH: begin
            if (cnt_ff == MAP_CW'(GLYPH_COLS)) state_in = ST_ACK;
         end
         ST_CTRL: begin
            if (fire && dev_last) state_in = upd_pix_ff ? ST_PIX_RD : ST_IDLE;
         end
         ST_PIX_RD: state_in = ST_PIX_OUT;
         ST_PIX_OUT: begin
            if (fire) state_in = pix_last ? ST_IDLE : ST_PIX_RD;
         end
         ST_ACK: begin
            if (fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs: queue pop, memory strobes and the result to be loaded.
   always_comb begin
      pop      = 1'b0;
      emit     = 1'b0;
      e_kind   = KIND_ACK;
      e_byte   = '0;
      e_rs     = 1'b0;
      e_fe     = 1'b0;
      e_last   = 1'b0;
      glyph_re = 1'b0;
      map_we   = 1'b0;
      map_re   = 1'b0;
      unique case (state_ff)
         ST_IDLE: pop = head.valid;
         ST_GLYPH: begin
            glyph_re = (cnt_ff < MAP_CW'(GLYPH_COLS));
            map_we   = (cnt_ff != '0);
         end
         ST_CTRL: begin
            emit   = 1'b1;
            e_kind = KIND_CTRL;
            e_byte = control_ff;
            e_rs   = 1'b1;
            e_fe   = 1'b1;
            e_last = dev_last && !upd_pix_ff;
         end
         ST_PIX_RD: map_re = 1'b1;
         ST_PIX_OUT: begin
            emit   = 1'b1;
            e_kind = KIND_PIXEL;
            e_byte = map_rd_vld_ff ? map_rd_ff : 8'h00;
            e_fe   = pix_last;
            e_last = pix_last;
         end
         ST_ACK: begin
            emit   = 1'b1;
            e_kind = ack_kind_ff;
            e_last = 1'b1;
         end
         default: ;
      endcase
   end

   // Control state, cursor, control word, dirty flags and map valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_ff     <= '0;
         control_ff    <= CONTROL_RESET;
         cdirty_ff     <= 1'b0;
         pdirty_ff     <= 1'b0;
         upd_pix_ff    <= 1'b0;
         cnt_ff        <= '0;
         glyph_base_ff <= '0;
         ack_kind_ff   <= KIND_ACK;
         map_vld_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            cnt_ff        <= '0;
            ack_kind_ff   <= KIND_ACK;
            glyph_base_ff <= head.cmd.glyph_base;
            unique case (head.cmd.op)
               OP_SETPOS: cursor_ff <= head.cmd.position;
               OP_CLEAR: begin
                  map_vld_ff <= '0;
                  pdirty_ff  <= 1'b1;
                  cursor_ff  <= '0;
               end
               OP_SLEEP: begin
                  // The sleep bit is high while awake; change only on a real toggle.
                  if (control_ff[SLEEP_BIT] == head.cmd.sleep) begin
                     control_ff[SLEEP_BIT] <= !head.cmd.sleep;
                     cdirty_ff             <= 1'b1;
                  end
               end
               OP_CURRENT: begin
                  control_ff[5:4] <= head.cmd.current_code;
                  cdirty_ff       <= 1'b1;
               end
               OP_BRIGHT: begin
                  control_ff[3:0] <= head.cmd.brightness;
                  cdirty_ff       <= 1'b1;
               end
               OP_UPDATE: begin
                  cdirty_ff  <= 1'b0;
                  pdirty_ff  <= 1'b0;
                  upd_pix_ff <= pdirty_ff;
                  if (!ctrl_send && !pdirty_ff) ack_kind_ff <= KIND_EMPTY;
               end
               default: ;
            endcase
         end
         // Glyph copy: five reads, each written to the map in the following cycle.
         if (state_ff == ST_GLYPH) begin
            if (cnt_ff == MAP_CW'(GLYPH_COLS)) begin
               cursor_ff <= cursor_ff + 1'b1;
               pdirty_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         if (map_we) map_vld_ff[map_waddr] <= 1'b1;
         // Byte counters for the update stream.
         if (state_ff == ST_CTRL && fire) cnt_ff <= dev_last ? '0 : cnt_ff + 1'b1;
         if (state_ff == ST_PIX_OUT && fire) cnt_ff <= cnt_ff + 1'b1;
      end
   end

   // Glyph store and pixel map memories with registered reads.
   always_ff @(posedge clock) begin
      if (glyph_we) glyph_mem[head.cmd.glyph_addr] <= head.cmd.glyph_byte;
      if (glyph_re) glyph_rd_ff <= glyph_mem[glyph_raddr];
      if (map_we) map_mem[map_waddr] <= glyph_rd_ff;
      if (map_re) begin
         map_rd_ff     <= map_mem[map_raddr];
         map_rd_vld_ff <= map_vld_ff[map_raddr];
      end
   end

   // Result output register; refilled as soon as the old item is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_kind_ff   <= e_kind;
         rsp_byte_ff   <= e_byte;
         rsp_rs_ff     <= e_rs;
         rsp_fe_ff     <= e_fe;
         rsp_cursor_ff <= 4'(cursor_ff);
         rsp_last_ff   <= e_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_reg_select = rsp_rs_ff;
   assign rsp_frame_end  = rsp_fe_ff;
   assign rsp_cursor     = rsp_cursor_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/char_display_pixel_map_ctrl_top.sv =====
// Top level of the character display pixel map controller: register port,
// front classifier, command queue and back executor. Depends on cdpm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Each request item returns one acknowledge item, except an update, which
// returns the control byte once per chained device (when the control word has
// changed) followed by the pixel map bytes of the characters in use (when the
// map has changed), or a single "nothing to send" item. Items pass through a
// two-entry command queue, so up to two requests are taken while a result is
// still waiting. The back part runs one command at a time: a character write
// within the length makes five glyph store reads, each written into the pixel
// map in the following cycle, through a single-port memory; an update takes the
// command, then sends each control byte, then reads each pixel byte from the
// registered pixel map before sending it; all other requests are taken and
// then acknowledged.
// Configuration registers are device_count at address 0 and char_length at
// address 4; they must only be written while the block is idle.

module char_display_pixel_map_ctrl_top
   import cdpm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [2:0]        req_type,
   input  wire logic [7:0]        req_char_code,
   input  wire logic [7:0]        req_new_position,
   input  wire logic              req_sleep_flag,
   input  wire logic [7:0]        req_current_level,
   input  wire logic [7:0]        req_brightness_level,
   input  wire logic [8:0]        req_glyph_addr,
   input  wire logic [7:0]        req_glyph_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_reg_select,
   output logic                   rsp_frame_end,
   output logic [3:0]             rsp_cursor,
   output logic                   rsp_last,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   logic [DEV_W-1:0]  device_count_ff;
   logic [LEN_W-1:0]  char_length_ff;
   logic              csr_write;
   csr_index_type     csr_index;
   logic [LEN_W-1:0]  eff_len;
   logic [DEV_W-1:0]  eff_devs;
   logic              queue_full;
   logic              push;
   cmd_type           push_cmd;
   logic              pop;
   queue_head_type    head;

   // Register port: zero wait states, word-aligned registers.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_count_ff <= DEV_W'(1);
         char_length_ff  <= LEN_W'(MAX_CHARS);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEVICE_COUNT: device_count_ff <= csr_pwdata[DEV_W-1:0];
            CSR_CHAR_LENGTH:  char_length_ff  <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_DEVICE_COUNT: csr_prdata = CSR_DW'(device_count_ff);
         CSR_CHAR_LENGTH:  csr_prdata = CSR_DW'(char_length_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Values in force after saturation.
   assign eff_len  = eff_length(char_length_ff);
   assign eff_devs = eff_devices(device_count_ff);

   cdpm_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_char_code        (req_char_code),
      .req_new_position     (req_new_position),
      .req_sleep_flag       (req_sleep_flag),
      .req_current_level    (req_current_level),
      .req_brightness_level (req_brightness_level),
      .req_glyph_addr       (req_glyph_addr),
      .req_glyph_byte       (req_glyph_byte),
      .eff_len              (eff_len),
      .queue_full           (queue_full),
      .push                 (push),
      .push_cmd             (push_cmd)
   );

   cdpm_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (queue_full),
      .pop      (pop),
      .head     (head)
   );

   cdpm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .eff_len        (eff_len),
      .eff_devs       (eff_devs),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_reg_select (rsp_reg_select),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_cursor     (rsp_cursor),
      .rsp_last       (rsp_last)
   );

   // Acknowledge and empty-update items are single, carry no byte and close the request.
   a_ack_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ACK || rsp_kind == KIND_EMPTY)
      |-> rsp_last && (rsp_out_byte == 8'h00) && !rsp_frame_end)
      else $error("acknowledge item malformed");

   // The cursor only advances while below the length, so it never passes the map size.
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor <= 4'(MAX_CHARS)))
      else $error("cursor beyond map size");

   // Control bytes always select the control register and end a frame.
   a_ctrl_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_CTRL) |-> rsp_reg_select && rsp_frame_end)
      else $error("control byte framing wrong");

   // Nothing is presented in the cycle after a reset cycle.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// ===== tb/cdpm_checker.sv =====
// Checker for the character display pixel map controller: keeps its own copy
// of the map, glyph store, control word and registers, predicts every result
// item and compares it with the block. Depends on cdpm_pkg.
`timescale 1ns / 1ps

module cdpm_checker
   import cdpm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic [2:0]        req_type,
   input  wire logic [7:0]        req_char_code,
   input  wire logic [7:0]        req_new_position,
   input  wire logic              req_sleep_flag,
   input  wire logic [7:0]        req_current_level,
   input  wire logic [7:0]        req_brightness_level,
   input  wire logic [8:0]        req_glyph_addr,
   input  wire logic [7:0]        req_glyph_byte,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [1:0]        rsp_kind,
   input  wire logic [7:0]        rsp_out_byte,
   input  wire logic              rsp_reg_select,
   input  wire logic              rsp_frame_end,
   input  wire logic [3:0]        rsp_cursor,
   input  wire logic              rsp_last,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   input  wire logic              csr_pready,
   output int                     mismatches,
   output int                     outstanding
);

   typedef struct {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       reg_select;
      logic       frame_end;
      logic [3:0] cursor;
      logic       last;
   } display_result_type;

   // Two-bit current field for each saturated peak current index.
   localparam logic [1:0] CURRENT_FIELD [4] = '{2'b10, 2'b01, 2'b00, 2'b11};

   display_result_type display_results[$];
   logic [7:0]      pixel_map [MAP_DEPTH];
   logic [7:0]      glyph_store [GLYPH_DEPTH];
   logic [7:0]      control_word;
   logic [3:0]      cursor_pos;
   logic            control_dirty;
   logic            pixel_dirty;
   logic [2:0]      device_cfg;
   logic [3:0]      length_cfg;
   int              fail_count = 0;

   assign mismatches = fail_count;

   function automatic int chars_in_use();
      int n;
      n = length_cfg;
      if (n == 0) n = 1;
      if (n > MAX_CHARS) n = MAX_CHARS;
      return n;
   endfunction

   function automatic void restore_reset_state();
      int i;
      for (i = 0; i < MAP_DEPTH; i++) pixel_map[i] = 8'h00;
      for (i = 0; i < GLYPH_DEPTH; i++) glyph_store[i] = 8'h00;
      control_word  = CONTROL_RESET;
      cursor_pos    = 4'd0;
      control_dirty = 1'b0;
      pixel_dirty   = 1'b0;
      device_cfg    = 3'd1;
      length_cfg    = 4'd8;
      display_results.delete();
   endfunction

   function automatic void add_result(kind_type kind, logic [7:0] value, logic rs,
                                      logic fe, logic lst);
      display_result_type r;
      r.kind       = kind;
      r.out_byte   = value;
      r.reg_select = rs;
      r.frame_end  = fe;
      r.cursor     = cursor_pos;
      r.last       = lst;
      display_results.push_back(r);
   endfunction

   // Applies one request item to the shadow state and queues what it must return.
   function automatic void predict_display(op_type op, logic [7:0] code, logic [7:0] pos,
                                           logic slp, logic [7:0] cur, logic [7:0] bri,
                                           logic [8:0] gaddr, logic [7:0] gbyte);
      int len, devs, nbytes, total, sent, shown, col, i;
      len  = chars_in_use();
      sent = 0;
      case (op)
         OP_WRITE: begin
            if (cursor_pos < len) begin
               shown = code;
               if (code < FIRST_CODE || code > LAST_CODE) shown = LAST_CODE;
               for (col = 0; col < GLYPH_COLS; col++)
                  pixel_map[cursor_pos * GLYPH_COLS + col] =
                     glyph_store[(shown - FIRST_CODE) * GLYPH_COLS + col];
               cursor_pos  = cursor_pos + 4'd1;
               pixel_dirty = 1'b1;
            end
         end
         OP_SETPOS: begin
            cursor_pos = (pos >= len) ? 4'(len - 1) : 4'(pos);
         end
         OP_CLEAR: begin
            for (i = 0; i < MAP_DEPTH; i++) pixel_map[i] = 8'h00;
            pixel_dirty = 1'b1;
            cursor_pos  = 4'd0;
         end
         OP_SLEEP: begin
            // The sleep bit is high while awake; only a real change marks the word.
            if (control_word[SLEEP_BIT] == slp) begin
               control_word[SLEEP_BIT] = !slp;
               control_dirty = 1'b1;
            end
         end
         OP_CURRENT: begin
            control_word[5:4] = CURRENT_FIELD[(cur > 3) ? 3 : int'(cur)];
            control_dirty = 1'b1;
         end
         OP_BRIGHT: begin
            control_word[3:0] = (bri > 15) ? 4'hf : bri[3:0];
            control_dirty = 1'b1;
         end
         OP_UPDATE: begin
            devs   = (device_cfg > MAX_DEVICES) ? MAX_DEVICES : int'(device_cfg);
            nbytes = len * GLYPH_COLS;
            total  = (control_dirty ? devs : 0) + (pixel_dirty ? nbytes : 0);
            if (control_dirty) begin
               for (i = 0; i < devs; i++) begin
                  sent++;
                  add_result(KIND_CTRL, control_word, 1'b1, 1'b1, sent == total);
               end
               control_dirty = 1'b0;
            end
            if (pixel_dirty) begin
               for (i = 0; i < nbytes; i++) begin
                  sent++;
                  add_result(KIND_PIXEL, pixel_map[i], 1'b0, i + 1 == nbytes, sent == total);
               end
               pixel_dirty = 1'b0;
            end
            if (sent == 0) add_result(KIND_EMPTY, 8'h00, 1'b0, 1'b0, 1'b1);
         end
         default: begin
            if (gaddr < GLYPH_DEPTH) glyph_store[gaddr] = gbyte;
         end
      endcase
      if (op != OP_UPDATE) add_result(KIND_ACK, 8'h00, 1'b0, 1'b0, 1'b1);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Results are checked before new requests, since a request taken at this
   // edge cannot have produced anything yet.
   always @(posedge clock) begin
      display_result_type want;
      if (reset) begin
         restore_reset_state();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[CSR_AW-1:2]))
               CSR_DEVICE_COUNT: device_cfg = csr_pwdata[2:0];
               CSR_CHAR_LENGTH:  length_cfg = csr_pwdata[3:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (display_results.size() == 0) begin
               $error("result item with no request waiting for it");
               fail_count++;
            end else begin
               want = display_results.pop_front();
               check_field("rsp_kind", want.kind, rsp_kind);
               check_field("rsp_out_byte", want.out_byte, rsp_out_byte);
               check_field("rsp_reg_select", want.reg_select, rsp_reg_select);
               check_field("rsp_frame_end", want.frame_end, rsp_frame_end);
               check_field("rsp_cursor", want.cursor, rsp_cursor);
               check_field("rsp_last", want.last, rsp_last);
            end
         end
         if (req_valid && req_ready)
            predict_display(op_type'(req_type), req_char_code, req_new_position,
                            req_sleep_flag, req_current_level, req_brightness_level,
                            req_glyph_addr, req_glyph_byte);
      end
      outstanding <= display_results.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the character display pixel map controller: clock, reset,
// request and register stimulus, result back-pressure and the verdict.
// Depends on cdpm_pkg, char_display_pixel_map_ctrl_top and cdpm_checker.
`timescale 1ns / 1ps

module tb_top;
   import cdpm_pkg::*;

   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 45;
   localparam int SETTLE_CYCLES = 16;

   // Register settings of the first random phases; later phases draw their own.
   localparam logic [2:0] PHASE_DEVICES [4] = '{3'd7, 3'd0, 3'd4, 3'd2};
   localparam logic [3:0] PHASE_LENGTHS [4] = '{4'd15, 4'd0, 4'd1, 4'd5};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic [2:0]        req_type = '0;
   logic [7:0]        req_char_code = '0;
   logic [7:0]        req_new_position = '0;
   logic              req_sleep_flag = 1'b0;
   logic [7:0]        req_current_level = '0;
   logic [7:0]        req_brightness_level = '0;
   logic [8:0]        req_glyph_addr = '0;
   logic [7:0]        req_glyph_byte = '0;
   logic              rsp_ready = 1'b0;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;

   logic              req_ready;
   logic              rsp_valid;
   logic [1:0]        rsp_kind;
   logic [7:0]        rsp_out_byte;
   logic              rsp_reg_select;
   logic              rsp_frame_end;
   logic [3:0]        rsp_cursor;
   logic              rsp_last;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;
   int                mismatches;
   int                outstanding;

   bit glyph_loaded [GLYPH_DEPTH];
   int items_sent = 0;
   int burst_left = 0;

   char_display_pixel_map_ctrl_top dut (.*);
   cdpm_checker checker_i (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   // Character codes favour a small set of glyphs, so loading stays cheap.
   function automatic logic [7:0] pick_code();
      if ($urandom_range(9) < 6) return 8'($urandom_range(8'h2f, 8'h20));
      return 8'($urandom);
   endfunction

   // Sends one request item. The operand goes to the field the operation reads;
   // every other field carries random content.
   task automatic send_item(input op_type op, input logic [7:0] arg, input logic [8:0] addr);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = idle_length();
         if ($urandom_range(19) == 0) burst_left = $urandom_range(30, 10);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_type             <= op;
      req_char_code        <= (op == OP_WRITE)   ? arg    : 8'($urandom);
      req_new_position     <= (op == OP_SETPOS)  ? arg    : 8'($urandom);
      req_sleep_flag       <= (op == OP_SLEEP)   ? arg[0] : 1'($urandom);
      req_current_level    <= (op == OP_CURRENT) ? arg    : 8'($urandom);
      req_brightness_level <= (op == OP_BRIGHT)  ? arg    : 8'($urandom);
      req_glyph_addr       <= (op == OP_LOAD)    ? addr   : 9'($urandom);
      req_glyph_byte       <= (op == OP_LOAD)    ? arg    : 8'($urandom);
      req_valid            <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (op == OP_LOAD && addr < GLYPH_DEPTH) glyph_loaded[addr] = 1'b1;
      items_sent++;
   endtask

   // Draws a character, first loading any glyph column that is still unknown.
   task automatic draw_char(input logic [7:0] code);
      int shown, col, slot;
      shown = code;
      if (code < FIRST_CODE || code > LAST_CODE) shown = LAST_CODE;
      for (col = 0; col < GLYPH_COLS; col++) begin
         slot = (shown - FIRST_CODE) * GLYPH_COLS + col;
         if (!glyph_loaded[slot]) send_item(OP_LOAD, 8'($urandom), 9'(slot));
      end
      send_item(OP_WRITE, code, '0);
   endtask

   // Holds the sender until every expected result has come and the block is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly whole frames (place the cursor, draw, maybe adjust the control word,
   // update), with single random requests in between.
   task automatic random_phase(input bit hold_midway);
      int start, n, k;
      op_type op;
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
         if (hold_midway && items_sent - start >= PHASE_ITEMS / 2) begin
            settle();
            hold_midway = 1'b0;
         end
         if ($urandom_range(99) < 55) begin
            if ($urandom_range(1)) send_item(OP_CLEAR, 8'($urandom), '0);
            else send_item(OP_SETPOS, ($urandom_range(3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(9)), '0);
            n = $urandom_range(MAX_CHARS + 1, 1);
            for (k = 0; k < n; k++) draw_char(pick_code());
            case ($urandom_range(5))
               0: send_item(OP_SLEEP, 8'($urandom_range(1)), '0);
               1: send_item(OP_CURRENT, ($urandom_range(3) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(3)), '0);
               2: send_item(OP_BRIGHT, ($urandom_range(3) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(15)), '0);
               default: ;
            endcase
            send_item(OP_UPDATE, 8'($urandom), '0);
         end else begin
            op = op_type'($urandom_range(7));
            if (op == OP_WRITE) draw_char(pick_code());
            else send_item(op, 8'($urandom), 9'($urandom));
         end
      end
   endtask

   // Result side: ready in runs, sometimes long ones, broken by stalls.
   initial begin
      int run, stall;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(6, 1);
         repeat (run) @(posedge clock);
         stall = idle_length();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Request side and verdict.
   initial begin
      int p, col;
      logic [2:0] devices;
      logic [3:0] length;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset register values: empty update, glyph
      // loads at both ends of the store and just beyond it, codes outside the
      // printable range, a clamped position, a write past the end, an
      // unchanged sleep state, a saturated current level and zero brightness.
      send_item(OP_UPDATE, 8'h00, '0);
      for (col = 0; col < GLYPH_COLS; col++)
         send_item(OP_LOAD, (col == 0) ? 8'h00 : 8'($urandom), 9'(col));
      for (col = 0; col < GLYPH_COLS; col++)
         send_item(OP_LOAD, (col == 4) ? 8'hff : 8'($urandom), 9'(GLYPH_DEPTH - 5 + col));
      send_item(OP_LOAD, 8'h5a, 9'(GLYPH_DEPTH));
      draw_char(FIRST_CODE);
      draw_char(LAST_CODE);
      draw_char(8'h00);
      draw_char(8'hff);
      send_item(OP_SETPOS, 8'hff, '0);
      draw_char(LAST_CODE);
      draw_char(FIRST_CODE);
      send_item(OP_SLEEP, 8'h01, '0);
      send_item(OP_SLEEP, 8'h01, '0);
      send_item(OP_CURRENT, 8'hff, '0);
      send_item(OP_BRIGHT, 8'h00, '0);
      send_item(OP_UPDATE, 8'h00, '0);
      send_item(OP_CLEAR, 8'h00, '0);
      send_item(OP_UPDATE, 8'h00, '0);

      for (p = 0; p < PHASES; p++) begin
         settle();
         if (p < 4) begin
            devices = PHASE_DEVICES[p];
            length  = PHASE_LENGTHS[p];
         end else begin
            devices = 3'($urandom);
            length  = 4'($urandom);
         end
         csr_write(CSR_DEVICE_COUNT, CSR_DW'(devices));
         csr_write(CSR_CHAR_LENGTH, CSR_DW'(length));
         random_phase(p == 1);
      end

      settle();
      if (mismatches == 0 && outstanding == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Run limit, far beyond the slowest correct run.
   initial begin
      #(10_000_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
